/* sv/fjsa_pkg.sv */
// fjsa_pkg: shared types and constants of the folded joint spectrum accumulator
// depends on nothing
`default_nettype none
package fjsa_pkg;
  localparam int unsigned Q15_W = 16;
  localparam logic [Q15_W-1:0] Q15_MAX = 16'hFFFF;
  localparam logic KIND_TRIPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FOLD,
    ST_READ,
    ST_OUT
  } state_t;

  // q1.15 product, truncated; two full-scale operands give up to 17 bits
  function automatic logic [Q15_W:0] qmul(input logic [Q15_W-1:0] a,
                                          input logic [Q15_W-1:0] b);
    logic [2*Q15_W-1:0] p;
    p = a * b;
    qmul = p[2*Q15_W-1:15];
  endfunction

  // q1.15 add that saturates at all ones
  function automatic logic [Q15_W-1:0] qadd_sat(input logic [Q15_W:0] a,
                                                input logic [Q15_W:0] b);
    logic [Q15_W+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    qadd_sat = (s > {2'b00, Q15_MAX}) ? Q15_MAX : s[Q15_W-1:0];
  endfunction
endpackage
`default_nettype wire

/* sv/fjsa_lane.sv */
// fjsa_lane: one convolution lane, computes one entry of the next vector
// depends on fjsa_pkg
`default_nettype none
module fjsa_lane (
  input  wire logic [fjsa_pkg::Q15_W-1:0] v0,   // conv[k]
  input  wire logic [fjsa_pkg::Q15_W-1:0] v1,   // conv[k-1]
  input  wire logic [fjsa_pkg::Q15_W-1:0] v2,   // conv[k-2]
  input  wire logic [fjsa_pkg::Q15_W-1:0] l0,
  input  wire logic [fjsa_pkg::Q15_W-1:0] l1,
  input  wire logic [fjsa_pkg::Q15_W-1:0] l2,
  output logic      [fjsa_pkg::Q15_W-1:0] sum
);
  import fjsa_pkg::*;
  // accumulation order matches g = 0, 1, 2
  always_comb begin
    sum = qadd_sat({1'b0, qadd_sat(qmul(v0, l0), qmul(v1, l1))}, qmul(v2, l2));
  end
endmodule
`default_nettype wire

/* sv/folded_joint_sfs_accumulator_core.sv */
// Folded two-population joint site frequency spectrum accumulator. A triple
// request is taken and its convolution is done by parallel lanes in the next
// cycle; with the receiver ready a triple then passes through result, result
// drain and idle before the next request. The last triple of a site instead
// walks the (2N0+1)x(2N1+1) outer product through a single multiplier and the
// spectrum memory port, each cell in turn (read, wait for data, write). A read
// request does a memory read and then outputs the cell. After reset a clearing
// pass zeroes the spectrum before the first request.
`default_nettype none
module folded_joint_sfs_accumulator_core #(
  parameter int POP0_INDIVIDUALS = 4,
  parameter int POP1_INDIVIDUALS = 4,
  parameter int ACC_WIDTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: lik_hom_major[15:0], lik_het[31:16], lik_hom_minor[47:32],
  //        read_row[51:48], read_col[55:52]
  input  wire logic [55:0] s_tdata,
  // tuser: kind
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: cell_value[47:0], site_done[48], saturated[49], zero fill
  output logic [55:0]      m_tdata
);
  import fjsa_pkg::*;

  localparam int ROWS = 2 * POP0_INDIVIDUALS + 1;
  localparam int COLS = 2 * POP1_INDIVIDUALS + 1;
  localparam int VLEN = (ROWS > COLS) ? ROWS : COLS;
  localparam int CELLS = ROWS * COLS;
  localparam int TOT = POP0_INDIVIDUALS + POP1_INDIVIDUALS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int IW = $clog2(TOT + 1);
  localparam logic [ACC_WIDTH-1:0] CAP = {ACC_WIDTH{1'b1}};

  // state and registers
  state_t state, state_next;
  logic [Q15_W-1:0] conv [VLEN];
  logic [Q15_W-1:0] pop0 [VLEN];
  logic [Q15_W-1:0] lik [3];
  logic [IW-1:0] ind;
  logic [3:0] rrow, rcol;
  logic [AW:0] clr_cnt;
  logic clearing;
  logic [RW-1:0] fi;
  logic [CW-1:0] fj;
  logic [ACC_WIDTH-1:0] mem [CELLS];
  logic mark [CELLS];
  logic [ACC_WIDTH-1:0] rd_val;
  logic rd_mark;
  logic [1:0] fph;
  logic [Q15_W:0] prod;
  logic [AW-1:0] faddr;
  logic [55:0] out_data;
  logic out_valid;
  logic [Q15_W-1:0] lane_sum [VLEN];

  // convolution lanes
  for (genvar k = 0; k < VLEN; k++) begin : g_lane
    logic [Q15_W-1:0] a0, a1, a2;
    logic [IW:0] pos2;
    always_comb begin
      pos2 = (ind < IW'(POP0_INDIVIDUALS)) ? {ind, 1'b0}
             : {ind - IW'(POP0_INDIVIDUALS), 1'b0};
      a0 = ((IW+1)'(k) <= pos2) ? conv[k] : '0;
      a1 = (k >= 1 && (IW+1)'(k - 1) <= pos2) ? conv[(k >= 1) ? k - 1 : 0] : '0;
      a2 = (k >= 2 && (IW+1)'(k - 2) <= pos2) ? conv[(k >= 2) ? k - 2 : 0] : '0;
    end
    fjsa_lane u_lane (.v0(a0), .v1(a1), .v2(a2), .l0(lik[0]), .l1(lik[1]),
                      .l2(lik[2]), .sum(lane_sum[k]));
  end

  logic first_pos;
  assign first_pos = (ind == '0) || (ind == IW'(POP0_INDIVIDUALS));
  logic last_ind;
  assign last_ind = (ind == IW'(TOT - 1));

  // fold address
  logic [RW+CW:0] fsum;
  logic [RW-1:0] fr;
  logic [CW-1:0] fc;
  always_comb begin
    fsum = (RW+CW+1)'(fi) + (RW+CW+1)'(fj);
    if (fsum >= (RW+CW+1)'(TOT)) begin
      fr = RW'(2 * POP0_INDIVIDUALS) - fi;
      fc = CW'(2 * POP1_INDIVIDUALS) - fj;
    end else begin
      fr = fi;
      fc = fj;
    end
    faddr = AW'(fr) * AW'(COLS) + AW'(fc);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid && s_tready) begin
        state_next = (s_tuser == KIND_READ) ? ST_READ : ST_CONV;
      end
      ST_CONV: state_next = last_ind ? ST_FOLD : ST_OUT;
      ST_FOLD: if (fph == 2'd2 && fi == RW'(ROWS - 1) && fj == CW'(COLS - 1)) begin
        state_next = ST_OUT;
      end
      ST_READ: state_next = ST_OUT;
      ST_OUT:  if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == ST_IDLE) && !clearing && !out_valid;
  end
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  logic [ACC_WIDTH:0] add_w;
  assign add_w = {1'b0, rd_val} + (ACC_WIDTH+1)'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ind <= '0;
      clearing <= 1'b1;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      fi <= '0;
      fj <= '0;
      fph <= '0;
      for (int k = 0; k < VLEN; k++) conv[k] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && m_tready) out_valid <= 1'b0;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW+1)'(CELLS - 1)) clearing <= 1'b0;
      end
      case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          lik[0] <= s_tdata[15:0];
          lik[1] <= s_tdata[31:16];
          lik[2] <= s_tdata[47:32];
          rrow <= s_tdata[51:48];
          rcol <= s_tdata[55:52];
        end
        ST_CONV: begin
          for (int k = 0; k < VLEN; k++) begin
            if (first_pos) conv[k] <= (k < 3) ? lik[(k < 3) ? k : 0] : '0;
            else conv[k] <= lane_sum[k];
          end
          if (ind == IW'(POP0_INDIVIDUALS - 1)) begin
            for (int k = 0; k < VLEN; k++)
              pop0[k] <= first_pos ? ((k < 3) ? lik[(k < 3) ? k : 0] : '0) : lane_sum[k];
          end
          if (last_ind) begin
            ind <= '0;
            fi <= '0;
            fj <= '0;
            fph <= '0;
          end else begin
            ind <= ind + 1'b1;
            out_data <= '0;
            out_valid <= 1'b1;
          end
        end
        ST_FOLD: begin
          // phase 0: product and read, phase 1: wait data, phase 2: write
          if (fph == 2'd2) begin
            fph <= '0;
            if (fj == CW'(COLS - 1)) begin
              fj <= '0;
              fi <= fi + 1'b1;
            end else fj <= fj + 1'b1;
            if (fi == RW'(ROWS - 1) && fj == CW'(COLS - 1)) begin
              out_data <= 56'd1 << 48;
              out_valid <= 1'b1;
            end
          end else begin
            fph <= fph + 1'b1;
          end
          if (fph == 2'd0) prod <= qmul(pop0[fi], conv[fj]);
        end
        ST_READ: begin
          if (int'(rrow) < ROWS && int'(rcol) < COLS) begin
            out_data <= {6'd0, rd_mark, 1'b0, 48'(rd_val)};
          end else begin
            out_data <= '0;
          end
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // spectrum memory, read address chosen by mode
  logic [AW-1:0] raddr;
  always_comb begin
    if (state == ST_IDLE) raddr = AW'(s_tdata[51:48]) * AW'(COLS) + AW'(s_tdata[55:52]);
    else raddr = faddr;
  end
  logic wr_en;
  logic [AW-1:0] waddr;
  logic [ACC_WIDTH-1:0] wdata;
  logic wmark;
  always_comb begin
    wr_en = clearing || (state == ST_FOLD && fph == 2'd2);
    waddr = clearing ? clr_cnt[AW-1:0] : faddr;
    wdata = '0;
    wmark = 1'b0;
    if (!clearing) begin
      if (add_w[ACC_WIDTH]) begin
        wdata = CAP;
        wmark = 1'b1;
      end else begin
        wdata = add_w[ACC_WIDTH-1:0];
        wmark = rd_mark;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
      mark[waddr] <= wmark;
    end
    rd_val <= mem[raddr];
    rd_mark <= mark[raddr];
  end

  // assertions
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("accept during clear");
  a_fold_ph: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FOLD) |-> ##1 (state == ST_FOLD) |-> fph == 2'd0)
    else $error("fold phase");
  a_ind_range: assert property (@(posedge clk) disable iff (rst)
    ind <= IW'(TOT - 1)) else $error("index range");
endmodule
`default_nettype wire
